/* design/thick_polyline_rasterizer_assert.svh */
// Assertion macros used by the rasterizer controller.
// Needs a clock named clk and an active-low reset named arst_n in the using module.
`ifndef THICK_POLYLINE_RASTERIZER_ASSERT_SVH
`define THICK_POLYLINE_RASTERIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TPR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define TPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TPR_ASSERT_IMPL(lbl, ante, cons, msg)
`define TPR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/tpr_pkg.sv */
// Shared types and codes of the thick polyline rasterizer.
// Used by the controller, the datapath and the top level; depends on nothing.
package tpr_pkg;

	localparam logic [1:0] OP_FIRST = 2'd0;
	localparam logic [1:0] OP_NEXT  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 40;

	localparam logic [REG_IDX_W-1:0] REG_WEST   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NORTH  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_XSCALE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_YSCALE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_PAINT  = 3'd7;

	typedef struct packed {
		logic load_in;
		logic clr;
		logic mul_y;
		logic mul_hi;
		logic acc_lo;
		logic acc_hi;
		logic clamp_x;
		logic clamp_y;
		logic seg_init;
		logic set_prev;
		logic sample;
		logic disc;
		logic dda_step;
		logic rd;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic draw;
		logic disc_last;
		logic seg_last;
	} sts_t;

endpackage

/* design/tpr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* design/tpr_ctrl.sv */
// Sequencing state machine of the rasterizer: clearing, mapping, segment walk, reads.
// Depends on tpr_pkg and the assertion header.
module tpr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    op,
	output logic          out_valid,
	input  logic          out_ready,
	output tpr_pkg::cmd_t cmd,
	input  tpr_pkg::sts_t sts
);
	import tpr_pkg::*;
	`include "thick_polyline_rasterizer_assert.svh"

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MAP_XL, S_MAP_XH, S_MAP_XA, S_MAP_XC, S_MAP_YH, S_MAP_YA,
		S_MAP_YC, S_DECIDE, S_SEG_INIT, S_SAMPLE, S_DISC, S_RD_ADDR, S_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: cmd.load_in = accept;
			S_MAP_XL: cmd.mul_hi = 1'b0;
			S_MAP_XH: begin
				cmd.mul_hi = 1'b1;
				cmd.acc_lo = 1'b1;
			end
			S_MAP_XA: cmd.acc_hi = 1'b1;
			S_MAP_XC: begin
				cmd.clamp_x = 1'b1;
				cmd.mul_y = 1'b1;
			end
			S_MAP_YH: begin
				cmd.mul_y = 1'b1;
				cmd.mul_hi = 1'b1;
				cmd.acc_lo = 1'b1;
			end
			S_MAP_YA: cmd.acc_hi = 1'b1;
			S_MAP_YC: cmd.clamp_y = 1'b1;
			S_DECIDE: cmd.set_prev = !sts.draw;
			S_SEG_INIT: begin
				cmd.seg_init = 1'b1;
				cmd.set_prev = 1'b1;
			end
			S_SAMPLE: cmd.sample = 1'b1;
			S_DISC: begin
				cmd.disc = 1'b1;
				cmd.dda_step = sts.disc_last & !sts.seg_last;
			end
			S_RD_ADDR: cmd.rd = 1'b1;
			S_RESULT: cmd.res_load = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESULT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: if (sts.clr_last) state_q <= S_IDLE;
				S_IDLE: begin
					if (accept) begin
						case (op)
							OP_FIRST, OP_NEXT: state_q <= S_MAP_XL;
							OP_READ: state_q <= S_RD_ADDR;
							default: state_q <= S_RESULT;
						endcase
					end
				end
				S_MAP_XL: state_q <= S_MAP_XH;
				S_MAP_XH: state_q <= S_MAP_XA;
				S_MAP_XA: state_q <= S_MAP_XC;
				S_MAP_XC: state_q <= S_MAP_YH;
				S_MAP_YH: state_q <= S_MAP_YA;
				S_MAP_YA: state_q <= S_MAP_YC;
				S_MAP_YC: state_q <= S_DECIDE;
				S_DECIDE: state_q <= sts.draw ? S_SEG_INIT : S_RESULT;
				S_SEG_INIT: state_q <= S_SAMPLE;
				S_SAMPLE: state_q <= S_DISC;
				S_DISC: begin
					if (sts.disc_last) begin
						state_q <= sts.seg_last ? S_RESULT : S_SAMPLE;
					end
				end
				S_RD_ADDR: state_q <= S_RESULT;
				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TPR_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != S_IDLE, "accepted item not started")
	`TPR_ASSERT_NEXT(a_seg_end_result, state_q == S_DISC && sts.disc_last && sts.seg_last, state_q == S_RESULT, "segment end did not reach result")
	`TPR_ASSERT_IMPL(a_result_no_overwrite, out_valid_q && !out_ready, !cmd.res_load, "pending result overwritten")
endmodule

/* design/tpr_datapath.sv */
// Datapath of the rasterizer: configuration, coordinate mapping, line stepping,
// disc scan and the mask memory. Depends on tpr_pkg and tpr_ram.
module tpr_datapath #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 15
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tpr_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [tpr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [1:0]                           op,
	input  logic signed [31:0]                   lat,
	input  logic signed [31:0]                   lon,
	input  logic [7:0]                           read_x,
	input  logic [7:0]                           read_y,
	output logic [7:0]                           pixel_value,
	input  tpr_pkg::cmd_t                        cmd,
	output tpr_pkg::sts_t                        sts
);
	import tpr_pkg::*;

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AWW   = $clog2(MAX_WIDTH + 1);
	localparam int AHW   = $clog2(MAX_HEIGHT + 1);
	localparam int LW    = (AWW > AHW) ? AWW : AHW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADW   = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int SW    = (XW > YW) ? XW : YW;
	localparam int PXW   = ((XW > RW) ? XW : RW) + 2;
	localparam int PYW   = ((YW > RW) ? YW : RW) + 2;

	logic signed [31:0] west_q, north_q;
	logic [39:0]        xsc_q, ysc_q;
	logic [8:0]         rw_q, rh_q;
	logic [3:0]         rad_q;
	logic [7:0]         paint_q;

	logic [1:0]         op_q;
	logic signed [31:0] lat_q, lon_q;
	logic [7:0]         read_x_q, read_y_q;

	logic [AWW-1:0] aw;
	logic [AHW-1:0] ah;
	logic [RW-1:0]  rr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			west_q <= '0;
			north_q <= '0;
			xsc_q <= 40'd65536;
			ysc_q <= 40'd65536;
			rw_q <= 9'd256;
			rh_q <= 9'd256;
			rad_q <= 4'd1;
			paint_q <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WEST: west_q <= cfg_data[31:0];
				REG_NORTH: north_q <= cfg_data[31:0];
				REG_XSCALE: xsc_q <= cfg_data;
				REG_YSCALE: ysc_q <= cfg_data;
				REG_WIDTH: rw_q <= cfg_data[8:0];
				REG_HEIGHT: rh_q <= cfg_data[8:0];
				REG_RADIUS: rad_q <= cfg_data[3:0];
				REG_PAINT: paint_q <= cfg_data[7:0];
				default: paint_q <= paint_q;
			endcase
		end
	end

	assign aw = (rw_q == '0) ? AWW'(1) :
		((32'(rw_q) > MAX_WIDTH) ? AWW'(MAX_WIDTH) : AWW'(rw_q));
	assign ah = (rh_q == '0) ? AHW'(1) :
		((32'(rh_q) > MAX_HEIGHT) ? AHW'(MAX_HEIGHT) : AHW'(rh_q));
	assign rr = (32'(rad_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= op;
			lat_q <= lat;
			lon_q <= lon;
			read_x_q <= read_x;
			read_y_q <= read_y;
		end
	end

	// Coordinate mapping: a 32x20 multiplier used for both halves of each scale.
	logic signed [32:0] dlon, dlat;
	logic [31:0]        opx, opy, mop;
	logic [19:0]        mpart;
	logic [51:0]        prod_q;
	logic [52:0]        acc_q;
	logic [34:0]        qv, lim, cq;
	logic [XW-1:0]      px_q, prev_x_q, x0_q, cx_q;
	logic [YW-1:0]      py_q, prev_y_q, y0_q, cy_q;
	logic               have_prev_q;

	assign dlon = 33'(lon_q) - 33'(west_q);
	assign dlat = 33'(north_q) - 33'(lat_q);
	assign opx = (!dlon[32] && dlon != '0) ? dlon[31:0] : '0;
	assign opy = (!dlat[32] && dlat != '0) ? dlat[31:0] : '0;
	assign mop = cmd.mul_y ? opy : opx;
	assign mpart = cmd.mul_y ? (cmd.mul_hi ? ysc_q[39:20] : ysc_q[19:0]) :
		(cmd.mul_hi ? xsc_q[39:20] : xsc_q[19:0]);
	assign qv = acc_q[52:18];
	assign lim = cmd.clamp_y ? 35'(LW'(ah) - LW'(1)) : 35'(LW'(aw) - LW'(1));
	assign cq = (qv > lim) ? lim : qv;

	always_ff @(posedge clk) begin
		prod_q <= {20'b0, mop} * {32'b0, mpart};
		if (cmd.acc_lo) begin
			acc_q <= 53'(prod_q >> 20);
		end else if (cmd.acc_hi) begin
			acc_q <= acc_q + {1'b0, prod_q};
		end
		if (cmd.clamp_x) begin
			px_q <= cq[XW-1:0];
		end
		if (cmd.clamp_y) begin
			py_q <= cq[YW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			have_prev_q <= 1'b0;
		end else if (cmd.set_prev) begin
			prev_x_q <= px_q;
			prev_y_q <= py_q;
			have_prev_q <= 1'b1;
		end
	end

	// Line stepping: quotient and remainder of s*|d|/steps advance by one compare-subtract.
	logic signed [XW:0] ddx;
	logic signed [YW:0] ddy;
	logic [SW-1:0]      adx, ady, steps;
	logic [SW-1:0]      adx_q, ady_q, steps_q, s_q, qx_q, qy_q, remx_q, remy_q;
	logic               negx_q, negy_q;
	logic [SW:0]        sumx, sumy;
	logic [SW-1:0]      cxw, cyw;

	assign ddx = $signed({1'b0, px_q}) - $signed({1'b0, prev_x_q});
	assign ddy = $signed({1'b0, py_q}) - $signed({1'b0, prev_y_q});
	assign adx = SW'(ddx[XW] ? -ddx : ddx);
	assign ady = SW'(ddy[YW] ? -ddy : ddy);
	assign steps = (adx > ady) ? adx : ady;
	assign sumx = {1'b0, remx_q} + {1'b0, adx_q};
	assign sumy = {1'b0, remy_q} + {1'b0, ady_q};
	assign cxw = negx_q ? (SW'(x0_q) - qx_q) : (SW'(x0_q) + qx_q);
	assign cyw = negy_q ? (SW'(y0_q) - qy_q) : (SW'(y0_q) + qy_q);

	always_ff @(posedge clk) begin
		if (cmd.seg_init) begin
			x0_q <= prev_x_q;
			y0_q <= prev_y_q;
			adx_q <= adx;
			ady_q <= ady;
			negx_q <= ddx[XW];
			negy_q <= ddy[YW];
			steps_q <= steps;
			s_q <= '0;
			qx_q <= '0;
			qy_q <= '0;
			remx_q <= '0;
			remy_q <= '0;
		end else if (cmd.dda_step) begin
			s_q <= s_q + SW'(1);
			if (sumx >= {1'b0, steps_q}) begin
				remx_q <= SW'(sumx - {1'b0, steps_q});
				qx_q <= qx_q + SW'(1);
			end else begin
				remx_q <= SW'(sumx);
			end
			if (sumy >= {1'b0, steps_q}) begin
				remy_q <= SW'(sumy - {1'b0, steps_q});
				qy_q <= qy_q + SW'(1);
			end else begin
				remy_q <= SW'(sumy);
			end
		end
	end

	// Disc scan: one offset pair per cycle, painted pixels go through a write register.
	logic signed [RW:0]  ox_q, oy_q, rs;
	logic [RW-1:0]       aox, aoy;
	logic [2*RW:0]       dsq;
	logic [2*RW-1:0]     rsq;
	logic signed [PXW-1:0] pxs;
	logic signed [PYW-1:0] pys;
	logic                paint_hit;
	logic                wr_en_q;
	logic [ADW-1:0]      wr_addr_q;
	logic [7:0]          wr_data_q;

	assign rs = $signed({1'b0, rr});
	assign aox = RW'(ox_q[RW] ? -ox_q : ox_q);
	assign aoy = RW'(oy_q[RW] ? -oy_q : oy_q);
	assign dsq = (2*RW+1)'((2*RW)'(aox) * (2*RW)'(aox)) +
		(2*RW+1)'((2*RW)'(aoy) * (2*RW)'(aoy));
	assign rsq = (2*RW)'(rr) * (2*RW)'(rr);
	assign pxs = PXW'($signed({2'b00, cx_q})) + PXW'(ox_q);
	assign pys = PYW'($signed({2'b00, cy_q})) + PYW'(oy_q);
	assign paint_hit = (dsq <= (2*RW+1)'(rsq)) &&
		!pxs[PXW-1] && ($unsigned(pxs) < PXW'(aw)) &&
		!pys[PYW-1] && ($unsigned(pys) < PYW'(ah));

	always_ff @(posedge clk) begin
		if (cmd.sample) begin
			cx_q <= XW'(cxw);
			cy_q <= YW'(cyw);
			ox_q <= -rs;
			oy_q <= -rs;
		end else if (cmd.disc) begin
			if (ox_q == rs) begin
				ox_q <= -rs;
				oy_q <= oy_q + (RW+1)'(1);
			end else begin
				ox_q <= ox_q + (RW+1)'(1);
			end
		end
		wr_addr_q <= ADW'(pys[YW-1:0]) * ADW'(MAX_WIDTH) + ADW'(pxs[XW-1:0]);
		wr_data_q <= paint_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_q <= 1'b0;
		end else begin
			wr_en_q <= cmd.disc & paint_hit;
		end
	end

	// Clearing pass, pixel reads and the result register.
	logic [ADW-1:0] clr_cnt_q;
	logic           rd_ok_q;
	logic           rd_ok;
	logic [ADW-1:0] rd_addr;
	logic           ram_we;
	logic [ADW-1:0] ram_waddr;
	logic [7:0]     ram_wdata, ram_rdata;
	logic [7:0]     pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + ADW'(1);
		end
	end

	assign rd_ok = (32'(read_x_q) < 32'(aw)) && (32'(read_y_q) < 32'(ah));
	assign rd_addr = ADW'(read_y_q) * ADW'(MAX_WIDTH) + ADW'(read_x_q);
	assign ram_we = cmd.clr | wr_en_q;
	assign ram_waddr = cmd.clr ? clr_cnt_q : wr_addr_q;
	assign ram_wdata = cmd.clr ? 8'd0 : wr_data_q;

	tpr_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_mask (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_ok_q <= rd_ok;
		end
		if (cmd.res_load) begin
			pixel_q <= (op_q == OP_READ && rd_ok_q) ? ram_rdata : 8'd0;
		end
	end

	assign pixel_value = pixel_q;
	assign sts.clr_last = (32'(clr_cnt_q) == DEPTH - 1);
	assign sts.draw = (op_q == OP_NEXT) && have_prev_q;
	assign sts.disc_last = (ox_q == rs) && (oy_q == rs);
	assign sts.seg_last = (s_q == steps_q);
endmodule

/* design/thick_polyline_rasterizer.sv */
// Top level of the thick polyline rasterizer: controller plus datapath.
// Depends on tpr_pkg, tpr_ctrl, tpr_datapath and tpr_ram.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   op, lat, lon, read_x, read_y
//   output   out_valid / out_ready pixel_value
//   config   cfg_we                cfg_index, cfg_data
//
// A read goes through the read-address state; a vertex first passes the
// mapping states of the shared 32x20 multiplier. A drawing vertex then
// scans (2r + 1)^2 disc offsets at each of its steps + 1 samples, one
// disc pixel per cycle. After reset a clearing pass writes the whole
// mask before the first transfer is taken. A stalled result holds the
// block in its result state; the next item is taken once it moves on.
module thick_polyline_rasterizer #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 15
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     op,
	input  logic signed [31:0]             lat,
	input  logic signed [31:0]             lon,
	input  logic [7:0]                     read_x,
	input  logic [7:0]                     read_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     pixel_value,
	input  logic                           cfg_we,
	input  logic [tpr_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tpr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	tpr_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_RADIUS(MAX_RADIUS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op         (op),
		.lat        (lat),
		.lon        (lon),
		.read_x     (read_x),
		.read_y     (read_y),
		.pixel_value(pixel_value),
		.cmd        (cmd),
		.sts        (sts)
	);
endmodule

/* tb/thick_polyline_rasterizer_tb.sv */
// Self-checking testbench for the thick polyline rasterizer: directed and random vertex and
// pixel-read transfers are checked against a behavioral mask model kept in this file.
// Depends on tpr_pkg and the thick_polyline_rasterizer top level.
module thick_polyline_rasterizer_tb;
	import tpr_pkg::*;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] lat;
		logic [31:0] lon;
		logic [7:0]  rx;
		logic [7:0]  ry;
	} vertex_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic signed [31:0] lat = '0;
	logic signed [31:0] lon = '0;
	logic [7:0] read_x = '0;
	logic [7:0] read_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] pixel_value;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	thick_polyline_rasterizer uut (.*);

	always #5 clk = ~clk;

	logic [7:0] mask_img [0:65535];
	int mdl_px, mdl_py;
	bit mdl_have;
	logic signed [31:0] m_west, m_north;
	logic [39:0] m_xs, m_ys;
	logic [8:0] m_w, m_h;
	logic [3:0] m_rad;
	logic [7:0] m_paint;

	vertex_item_t pending_items[$];
	logic [7:0] expected_pixels[$];
	int errors = 0;
	bit quiet = 1'b0;
	bit hold_off = 1'b0;
	int n_draws = 0, n_reads = 0, n_results = 0;

	function automatic int act_w();
		if (m_w == 0) return 1;
		if (m_w > 256) return 256;
		return m_w;
	endfunction

	function automatic int act_h();
		if (m_h == 0) return 1;
		if (m_h > 256) return 256;
		return m_h;
	endfunction

	function automatic int map_pixel(longint d, logic [39:0] sc, int lim);
		logic [127:0] q;
		if (d <= 0) return 0;
		q = (128'(d) * 128'(sc)) >> 38;
		if (q > lim - 1) return lim - 1;
		return int'(q);
	endfunction

	task automatic paint_brush(int cx, int cy, int r, int w, int h);
		int x, y;
		for (int dy = -r; dy <= r; dy++)
			for (int dx = -r; dx <= r; dx++) begin
				x = cx + dx;
				y = cy + dy;
				if (dx * dx + dy * dy > r * r) continue;
				if (x < 0 || x >= w || y < 0 || y >= h) continue;
				mask_img[y * 256 + x] = m_paint;
			end
	endtask

	task automatic predict_pixel(vertex_item_t it);
		int w, h, px, py, ddx, ddy, steps, r;
		logic [7:0] res;
		w = act_w();
		h = act_h();
		res = '0;
		if (it.op == OP_FIRST || it.op == OP_NEXT) begin
			px = map_pixel(longint'($signed(it.lon)) - longint'(m_west), m_xs, w);
			py = map_pixel(longint'(m_north) - longint'($signed(it.lat)), m_ys, h);
			if (it.op == OP_NEXT && mdl_have) begin
				r = m_rad > 15 ? 15 : m_rad;
				ddx = px - mdl_px;
				ddy = py - mdl_py;
				steps = (ddx < 0 ? -ddx : ddx) > (ddy < 0 ? -ddy : ddy) ?
					(ddx < 0 ? -ddx : ddx) : (ddy < 0 ? -ddy : ddy);
				for (int s = 0; s <= steps; s++)
					paint_brush(steps ? mdl_px + (s * ddx) / steps : mdl_px,
						steps ? mdl_py + (s * ddy) / steps : mdl_py, r, w, h);
				n_draws++;
			end
			mdl_px = px;
			mdl_py = py;
			mdl_have = 1'b1;
		end else if (it.op == OP_READ) begin
			n_reads++;
			if (it.rx < w && it.ry < h) res = mask_img[it.ry * 256 + it.rx];
		end
		expected_pixels.insert(expected_pixels.size(), res);
	endtask

	int gap = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_pixel({op, lat, lon, read_x, read_y});
		end
		if (!in_valid || in_ready) begin
			if (gap > 0) begin
				gap <= gap - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0 && arst_n) begin
				vertex_item_t it;
				it = pending_items.pop_front();
				{op, lat, lon, read_x, read_y} <= it;
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0) gap <= $urandom_range(1, 15);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	int stall = 0;
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			n_results++;
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d", $time, pixel_value);
				errors++;
			end else begin
				logic [7:0] e;
				e = expected_pixels.pop_front();
				if (pixel_value !== e) begin
					$display("%0t: pixel_value expected %0d actual %0d", $time, e, pixel_value);
					errors++;
				end
			end
		end
		if (hold_off) begin
			out_ready <= 1'b0;
		end else if (stall > 0) begin
			stall <= stall - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			stall <= $urandom_range(0, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WEST: m_west = val[31:0];
			REG_NORTH: m_north = val[31:0];
			REG_XSCALE: m_xs = val[39:0];
			REG_YSCALE: m_ys = val[39:0];
			REG_WIDTH: m_w = val[8:0];
			REG_HEIGHT: m_h = val[8:0];
			REG_RADIUS: m_rad = val[3:0];
			default: m_paint = val[7:0];
		endcase
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic vertex_item_t make_item(logic [1:0] o, logic [31:0] la, logic [31:0] lo,
			logic [7:0] x, logic [7:0] y);
		vertex_item_t it;
		it.op = o;
		it.lat = la;
		it.lon = lo;
		it.rx = x;
		it.ry = y;
		return it;
	endfunction

	function automatic void queue_item(vertex_item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	// Vertices of one degree per pixel at unit scales: lat/lon in whole pixels times 2^22.
	function automatic vertex_item_t near_vertex(logic [1:0] o);
		return make_item(o, -($urandom_range(0, 40) << 22) - $urandom_range(0, 4194303),
			($urandom_range(0, 40) << 22) + $urandom_range(0, 4194303),
			8'($urandom), 8'($urandom));
	endfunction

	task automatic random_phase(int n);
		vertex_item_t it;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: it = make_item(2'($urandom), $urandom, $urandom, 8'($urandom),
					8'($urandom));
				1, 2: it = near_vertex(OP_FIRST);
				3, 4, 5: it = near_vertex(OP_NEXT);
				default: it = make_item(OP_READ, $urandom, $urandom,
					8'($urandom_range(0, 45)), 8'($urandom_range(0, 45)));
			endcase
			queue_item(it);
		end
	endtask

	initial begin
		for (int i = 0; i < 65536; i++) mask_img[i] = '0;
		mdl_px = 0;
		mdl_py = 0;
		mdl_have = 1'b0;
		m_west = 0;
		m_north = 0;
		m_xs = 40'd65536;
		m_ys = 40'd65536;
		m_w = 9'd256;
		m_h = 9'd256;
		m_rad = 4'd1;
		m_paint = 8'd255;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reads before any vertex, a next vertex with no predecessor, extremes.
		queue_item(make_item(OP_READ, 0, 0, 8'd0, 8'd0));
		queue_item(make_item(OP_READ, 0, 0, 8'd255, 8'd255));
		queue_item(make_item(OP_NEXT, -32'sd41943040, 32'sd41943040, 8'd0, 8'd0));
		queue_item(make_item(OP_READ, 0, 0, 8'd10, 8'd10));
		queue_item(make_item(OP_NEXT, -32'sd83886080, 32'sd125829120, 8'd0, 8'd0));
		queue_item(make_item(OP_READ, 0, 0, 8'd20, 8'd15));
		queue_item(make_item(OP_READ, 0, 0, 8'd30, 8'd20));
		queue_item(make_item(OP_FIRST, 32'h7fffffff, 32'h80000000, 8'd0, 8'd0));
		queue_item(make_item(OP_NEXT, 32'h80000000, 32'h7fffffff, 8'd0, 8'd0));
		queue_item(make_item(OP_READ, 0, 0, 8'd255, 8'd255));
		queue_item(make_item(OP_READ, 0, 0, 8'd254, 8'd0));
		queue_item(make_item(2'd3, 32'hffffffff, 32'hffffffff, 8'hff, 8'hff));
		queue_item(make_item(OP_READ, 0, 0, 8'd0, 8'd255));
		wait_idle();

		write_reg(REG_WIDTH, 40'd40);
		write_reg(REG_HEIGHT, 40'd45);
		write_reg(REG_RADIUS, 40'd3);
		write_reg(REG_PAINT, 40'd90);
		write_reg(REG_WEST, 40'hfff0000000);
		write_reg(REG_NORTH, 40'd8388608);
		queue_item(make_item(OP_READ, 0, 0, 8'd255, 8'd255));
		queue_item(make_item(OP_READ, 0, 0, 8'd39, 8'd44));
		queue_item(make_item(OP_READ, 0, 0, 8'd40, 8'd0));
		random_phase(35);
		wait_idle();

		// Long output hold-off with random items waiting at the input.
		hold_off = 1'b1;
		random_phase(12);
		repeat (3000) @(posedge clk);
		hold_off = 1'b0;
		wait_idle();

		write_reg(REG_XSCALE, 40'hffffffffff);
		write_reg(REG_YSCALE, 40'd0);
		write_reg(REG_WIDTH, 40'd0);
		write_reg(REG_HEIGHT, 40'd511);
		write_reg(REG_RADIUS, 40'd15);
		write_reg(REG_PAINT, 40'd0);
		random_phase(10);
		wait_idle();

		write_reg(REG_XSCALE, 40'd70000);
		write_reg(REG_YSCALE, 40'd60000);
		write_reg(REG_WIDTH, 40'd300);
		write_reg(REG_HEIGHT, 40'd50);
		write_reg(REG_RADIUS, 40'd0);
		write_reg(REG_PAINT, 40'd255);
		write_reg(REG_WEST, 40'd0);
		write_reg(REG_NORTH, 40'd0);
		random_phase(20);
		wait_idle();

		write_reg(REG_RADIUS, 40'd2);
		write_reg(REG_PAINT, 40'd171);
		quiet = 1'b1;
		random_phase(20);
		wait_idle();
		repeat (100) @(posedge clk);

		$display("Covered %0d segment draws and %0d pixel reads; %0d results checked.",
			n_draws, n_reads, n_results);
		if (errors == 0 && expected_pixels.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#200000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
